// File: rtl/efla_pkg.sv
// Shared types, constants and codes for the explicit free-list allocator.
`default_nettype none
package efla_pkg;

  // Heap memory geometry
  localparam int HEAP_WORDS = 16384;
  localparam int HEAP_AW    = $clog2(HEAP_WORDS);
  localparam int WALK_BOUND = HEAP_WORDS / 4 + 2;
  localparam int STEP_W     = $clog2(WALK_BOUND + 1);
  localparam int LIM_CAP    = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;

  localparam logic [16:0] CHUNK_RESET = 17'd4096;
  localparam logic [16:0] LIMIT_RESET = 17'd65536;
  localparam logic [31:0] MIN_BLOCK   = 32'd16;
  localparam logic [16:0] FRAME_BYTES = 17'd24;
  localparam logic [31:0] SIZE_MASK   = 32'hFFFF_FFF8;

  // Action codes
  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_REALLOC = 2'd3
  } action_t;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_NOT_INIT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHUNK = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [16:0] request_bytes;
    logic [15:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [1:0]  status;
  } out_item_t;

  // Datapath commands
  typedef enum logic [5:0] {
    C_NOP, C_ASIZE, C_FF_RH, C_FF_CH, C_FF_NX, C_G0, C_G1, C_TAGH, C_TAGF,
    C_EPI, C_M0, C_M1, C_M2, C_M3, C_M4, C_M5, C_DT_PB, C_DT_NB, C_MFIN,
    C_P0, C_P1, C_P2, C_D0, C_D1, C_D2, C_D3, C_C0, C_C1, C_C2, C_C5,
    C_AEND, C_F0, C_F1, C_I0, C_IW, C_I7
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       tag_used;
    logic       st_we;
    logic [1:0] st_val;
    logic       res_clr;
    logic       ld_item;
    logic       ld_out;
  } ctl_t;

  typedef struct packed {
    action_t action;
    logic    req_zero;
    logic    addr_zero;
    logic    initialized;
    logic    lim_small;
    logic    used;
    logic    fit;
    logic    steps_done;
    logic    grow_fail;
    logic    pused;
    logic    nused;
    logic    head_eq;
    logic    split_ok;
    logic    iw_last;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/efla_dpath.sv
// Allocator datapath: heap memory, heap registers and block arithmetic.
`default_nettype none
module efla_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire efla_pkg::ctl_t    ctl,
  output efla_pkg::stat_t        stat,
  input  wire efla_pkg::in_item_t item,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [16:0]       cfg_data,
  output efla_pkg::out_item_t    result
);

  // Heap memory
  logic [31:0] mem [efla_pkg::HEAP_WORDS];
  logic [31:0] mem_q;
  logic        rd_ok_q;

  // Configuration and heap state
  logic [16:0] chunk, limit, brk;
  logic [15:0] head;
  logic        init_f;

  // Working registers
  efla_pkg::in_item_t item_q;
  logic [17:0] asize, gsz;
  logic [31:0] bp, pb, nb, dt, s, p, size, psz, nsz, csize;
  logic        pused, nused;
  logic [efla_pkg::STEP_W-1:0] steps;
  logic [2:0]  iw;
  logic [15:0] abp, res;
  logic [1:0]  st;

  logic [31:0] q, qs;
  logic [31:0] m_addr, m_wd;
  logic        m_we, in_range;
  logic [16:0] lim_eff;
  logic [17:0] ext, gr_t, gr;
  logic [17:0] asize_calc;
  logic [31:0] asize32;
  logic        split;

  function automatic logic [31:0] frame_word(input logic [2:0] i);
    logic [31:0] w;
    case (i)
      3'd1, 3'd4: w = efla_pkg::MIN_BLOCK | 32'd1;
      3'd5:       w = 32'd1;
      default:    w = 32'd0;
    endcase
    return w;
  endfunction

  // Read data: words past the end read as zero
  assign q  = rd_ok_q ? mem_q : 32'd0;
  assign qs = q & efla_pkg::SIZE_MASK;

  assign lim_eff = (limit > 17'(efla_pkg::LIM_CAP)) ? 17'(efla_pkg::LIM_CAP) : limit;
  assign ext     = (asize > {1'b0, chunk}) ? asize : {1'b0, chunk};
  assign gr_t    = ({ext[17:2], 2'b00} + 18'd4) & ~18'd7;
  assign gr      = (gr_t < 18'd16) ? 18'd16 : gr_t;
  assign asize_calc = (item_q.request_bytes <= 17'd8) ? 18'd16 :
                      (({1'b0, item_q.request_bytes} + 18'd15) & ~18'd7);
  assign asize32 = {14'd0, asize};
  assign split   = ((csize - asize32) >= efla_pkg::MIN_BLOCK) && (csize >= asize32);

  // Status to the controller
  always_comb begin
    stat.action      = efla_pkg::action_t'(item_q.action);
    stat.req_zero    = (item_q.request_bytes == 17'd0);
    stat.addr_zero   = (item_q.block_addr == 16'd0);
    stat.initialized = init_f;
    stat.lim_small   = (lim_eff < efla_pkg::FRAME_BYTES);
    stat.used        = q[0];
    stat.fit         = (asize32 <= qs);
    stat.steps_done  = (steps >= efla_pkg::STEP_W'(efla_pkg::WALK_BOUND));
    stat.grow_fail   = (({2'b00, brk} + {1'b0, gsz}) > {2'b00, lim_eff});
    stat.pused       = pused;
    stat.nused       = nused;
    stat.head_eq     = (dt == {16'd0, head});
    stat.split_ok    = split;
    stat.iw_last     = (iw == 3'd5);
  end

  // Memory port selection
  always_comb begin
    m_addr = bp;
    m_we   = 1'b0;
    m_wd   = 32'd0;
    case (ctl.cmd)
      efla_pkg::C_FF_RH: m_addr = bp - 32'd4;
      efla_pkg::C_FF_CH: m_addr = bp + 32'd4;
      efla_pkg::C_FF_NX: m_addr = q - 32'd4;
      efla_pkg::C_TAGH: begin
        m_addr = bp - 32'd4;
        m_we   = 1'b1;
        m_wd   = size | {31'd0, ctl.tag_used};
      end
      efla_pkg::C_TAGF: begin
        m_addr = bp + size - 32'd8;
        m_we   = 1'b1;
        m_wd   = size | {31'd0, ctl.tag_used};
      end
      efla_pkg::C_EPI: begin
        m_addr = bp + size - 32'd4;
        m_we   = 1'b1;
        m_wd   = 32'd1;
      end
      efla_pkg::C_M0: m_addr = bp - 32'd8;
      efla_pkg::C_M1: m_addr = bp - qs - 32'd4;
      efla_pkg::C_M2: m_addr = pb + qs - 32'd8;
      efla_pkg::C_M3: m_addr = bp - 32'd4;
      efla_pkg::C_M4: m_addr = bp + qs - 32'd4;
      efla_pkg::C_P0: begin
        m_addr = bp + 32'd4;
        m_we   = 1'b1;
        m_wd   = {16'd0, head};
      end
      efla_pkg::C_P1: begin
        m_addr = bp;
        m_we   = 1'b1;
      end
      efla_pkg::C_P2: begin
        m_addr = {16'd0, head};
        m_we   = 1'b1;
        m_wd   = bp;
      end
      efla_pkg::C_D0: m_addr = dt + 32'd4;
      efla_pkg::C_D1: begin
        if (stat.head_eq) begin
          m_addr = q;
          m_we   = 1'b1;
        end else begin
          m_addr = dt;
        end
      end
      efla_pkg::C_D2: begin
        m_addr = q + 32'd4;
        m_we   = 1'b1;
        m_wd   = s;
      end
      efla_pkg::C_D3: begin
        m_addr = s;
        m_we   = 1'b1;
        m_wd   = p;
      end
      efla_pkg::C_C0: m_addr = bp - 32'd4;
      efla_pkg::C_F0: m_addr = {16'd0, item_q.block_addr} - 32'd4;
      efla_pkg::C_IW: begin
        m_addr = {27'd0, iw, 2'b00};
        m_we   = 1'b1;
        m_wd   = frame_word(iw);
      end
      default: m_addr = bp;
    endcase
  end

  assign in_range = (m_addr >> 2) < 32'(efla_pkg::HEAP_WORDS);

  // Heap memory, registered read
  always_ff @(posedge clk) begin
    if (m_we && in_range) begin
      mem[m_addr[efla_pkg::HEAP_AW+1:2]] <= m_wd;
    end
    mem_q   <= mem[m_addr[efla_pkg::HEAP_AW+1:2]];
    rd_ok_q <= in_range;
  end

  // Control state: configuration and heap bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk  <= efla_pkg::CHUNK_RESET;
      limit  <= efla_pkg::LIMIT_RESET;
      brk    <= 17'd0;
      head   <= 16'd0;
      init_f <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == efla_pkg::CFG_CHUNK) chunk <= cfg_data;
        if (cfg_index == efla_pkg::CFG_LIMIT) limit <= cfg_data;
      end
      case (ctl.cmd)
        efla_pkg::C_G1: brk <= brk + gsz[16:0];
        efla_pkg::C_P2: head <= bp[15:0];
        efla_pkg::C_D1: if (stat.head_eq) head <= q[15:0];
        efla_pkg::C_I0: begin
          brk    <= 17'd0;
          head   <= 16'd0;
          init_f <= 1'b0;
        end
        efla_pkg::C_I7: begin
          brk    <= efla_pkg::FRAME_BYTES;
          head   <= 16'd8;
          init_f <= 1'b1;
        end
        default: init_f <= init_f;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.ld_item) item_q <= item;
    if (ctl.res_clr) res <= 16'd0;
    if (ctl.st_we) st <= ctl.st_val;
    if (ctl.ld_out) begin
      result.result_addr <= res;
      result.status      <= st;
    end
    case (ctl.cmd)
      efla_pkg::C_ASIZE: begin
        asize <= asize_calc;
        bp    <= {16'd0, head};
        steps <= '0;
      end
      efla_pkg::C_FF_NX: begin
        bp    <= q;
        steps <= steps + 1'b1;
      end
      efla_pkg::C_G0: gsz <= gr;
      efla_pkg::C_G1: begin
        bp   <= {15'd0, brk};
        size <= {14'd0, gsz};
      end
      efla_pkg::C_M1: pb <= bp - qs;
      efla_pkg::C_M2: psz <= qs;
      efla_pkg::C_M3: pused <= q[0];
      efla_pkg::C_M4: begin
        size <= qs;
        nb   <= bp + qs;
      end
      efla_pkg::C_M5: begin
        nused <= q[0];
        nsz   <= qs;
      end
      efla_pkg::C_DT_PB: dt <= pb;
      efla_pkg::C_DT_NB: dt <= nb;
      efla_pkg::C_MFIN: begin
        size <= size + (pused ? 32'd0 : psz) + (nused ? 32'd0 : nsz);
        if (!pused) bp <= pb;
      end
      efla_pkg::C_D1: s <= q;
      efla_pkg::C_D2: p <= q;
      efla_pkg::C_C0: abp <= bp[15:0];
      efla_pkg::C_C1: begin
        csize <= qs;
        dt    <= bp;
      end
      efla_pkg::C_C2: size <= split ? asize32 : csize;
      efla_pkg::C_C5: begin
        bp   <= bp + asize32;
        size <= csize - asize32;
      end
      efla_pkg::C_AEND: res <= abp;
      efla_pkg::C_F0: bp <= {16'd0, item_q.block_addr};
      efla_pkg::C_F1: size <= qs;
      efla_pkg::C_I0: begin
        asize <= 18'd0;
        iw    <= 3'd0;
      end
      efla_pkg::C_IW: iw <= iw + 3'd1;
      default: steps <= steps;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/efla_ctrl.sv
// Allocator controller: sequences heap operations as datapath commands.
`default_nettype none
module efla_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  wire logic            result_ready,
  input  wire efla_pkg::stat_t stat,
  output efla_pkg::ctl_t       ctl
);

  localparam int NS = 47;

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,  S_DISP  = NS'(1) << 1,  S_A0    = NS'(1) << 2,
    S_FF_RH = NS'(1) << 3,  S_FF_CH = NS'(1) << 4,  S_FF_NX = NS'(1) << 5,
    S_G0    = NS'(1) << 6,  S_G1    = NS'(1) << 7,  S_G2    = NS'(1) << 8,
    S_G3    = NS'(1) << 9,  S_G4    = NS'(1) << 10, S_M0    = NS'(1) << 11,
    S_M1    = NS'(1) << 12, S_M2    = NS'(1) << 13, S_M3    = NS'(1) << 14,
    S_M4    = NS'(1) << 15, S_M5    = NS'(1) << 16, S_M6    = NS'(1) << 17,
    S_MDP   = NS'(1) << 18, S_MDN   = NS'(1) << 19, S_MFIN  = NS'(1) << 20,
    S_MT0   = NS'(1) << 21, S_MT1   = NS'(1) << 22, S_MP0   = NS'(1) << 23,
    S_MP1   = NS'(1) << 24, S_MP2   = NS'(1) << 25, S_D0    = NS'(1) << 26,
    S_D1    = NS'(1) << 27, S_D2    = NS'(1) << 28, S_D3    = NS'(1) << 29,
    S_C0    = NS'(1) << 30, S_C1    = NS'(1) << 31, S_C2    = NS'(1) << 32,
    S_C3    = NS'(1) << 33, S_C4    = NS'(1) << 34, S_C5    = NS'(1) << 35,
    S_C6    = NS'(1) << 36, S_C7    = NS'(1) << 37, S_AEND  = NS'(1) << 38,
    S_F0    = NS'(1) << 39, S_F1    = NS'(1) << 40, S_F2    = NS'(1) << 41,
    S_F3    = NS'(1) << 42, S_I0    = NS'(1) << 43, S_IW    = NS'(1) << 44,
    S_I7    = NS'(1) << 45, S_DONE  = NS'(1) << 46
  } state_t;

  // Who gets control back after a push finishes
  typedef enum logic [1:0] {
    CL_INIT, CL_ALLOC, CL_FREE, CL_CARVE
  } caller_t;

  state_t  state, state_next, ret, ret_next;
  caller_t caller, caller_next;
  logic    free_after, free_after_next;
  logic    result_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    ret_next          = ret;
    caller_next       = caller;
    free_after_next   = free_after;
    result_valid_next = result_valid;
    ctl               = '0;
    ctl.cmd           = efla_pkg::C_NOP;
    if (result_valid && result_ready) result_valid_next = 1'b0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.ld_item = 1'b1;
          state_next  = S_DISP;
        end
      end
      // Decode the action
      S_DISP: begin
        ctl.res_clr     = 1'b1;
        free_after_next = 1'b0;
        if (stat.action == efla_pkg::ACT_INIT) begin
          caller_next = CL_INIT;
          state_next  = S_I0;
        end else if (!stat.initialized) begin
          ctl.st_we  = 1'b1;
          ctl.st_val = efla_pkg::ST_NOT_INIT;
          state_next = S_DONE;
        end else begin
          case (stat.action)
            efla_pkg::ACT_ALLOC: begin
              if (stat.req_zero) begin
                ctl.st_we  = 1'b1;
                ctl.st_val = efla_pkg::ST_IGNORED;
                state_next = S_DONE;
              end else begin
                caller_next = CL_ALLOC;
                state_next  = S_A0;
              end
            end
            efla_pkg::ACT_FREE: begin
              ctl.st_we = 1'b1;
              if (stat.addr_zero) begin
                ctl.st_val = efla_pkg::ST_IGNORED;
                state_next = S_DONE;
              end else begin
                ctl.st_val  = efla_pkg::ST_OK;
                caller_next = CL_FREE;
                state_next  = S_F0;
              end
            end
            default: begin
              if (stat.req_zero) begin
                ctl.st_we  = 1'b1;
                ctl.st_val = efla_pkg::ST_IGNORED;
                if (stat.addr_zero) begin
                  state_next = S_DONE;
                end else begin
                  caller_next = CL_FREE;
                  state_next  = S_F0;
                end
              end else begin
                caller_next     = CL_ALLOC;
                free_after_next = !stat.addr_zero;
                state_next      = S_A0;
              end
            end
          endcase
        end
      end
      // First-fit walk
      S_A0: begin
        ctl.cmd    = efla_pkg::C_ASIZE;
        state_next = S_FF_RH;
      end
      S_FF_RH: begin
        ctl.cmd    = efla_pkg::C_FF_RH;
        state_next = S_FF_CH;
      end
      S_FF_CH: begin
        ctl.cmd = efla_pkg::C_FF_CH;
        if (stat.used || stat.steps_done) state_next = S_G0;
        else if (stat.fit)                state_next = S_C0;
        else                              state_next = S_FF_NX;
      end
      S_FF_NX: begin
        ctl.cmd    = efla_pkg::C_FF_NX;
        state_next = S_FF_CH;
      end
      // Heap growth
      S_G0: begin
        ctl.cmd    = efla_pkg::C_G0;
        state_next = S_G1;
      end
      S_G1: begin
        if (stat.grow_fail) begin
          ctl.st_we  = 1'b1;
          ctl.st_val = efla_pkg::ST_OOM;
          state_next = S_DONE;
        end else begin
          ctl.cmd    = efla_pkg::C_G1;
          state_next = S_G2;
        end
      end
      S_G2: begin
        ctl.cmd    = efla_pkg::C_TAGH;
        state_next = S_G3;
      end
      S_G3: begin
        ctl.cmd    = efla_pkg::C_TAGF;
        state_next = S_G4;
      end
      S_G4: begin
        ctl.cmd    = efla_pkg::C_EPI;
        state_next = S_M0;
      end
      // Coalesce with neighbors
      S_M0: begin ctl.cmd = efla_pkg::C_M0; state_next = S_M1; end
      S_M1: begin ctl.cmd = efla_pkg::C_M1; state_next = S_M2; end
      S_M2: begin ctl.cmd = efla_pkg::C_M2; state_next = S_M3; end
      S_M3: begin ctl.cmd = efla_pkg::C_M3; state_next = S_M4; end
      S_M4: begin ctl.cmd = efla_pkg::C_M4; state_next = S_M5; end
      S_M5: begin ctl.cmd = efla_pkg::C_M5; state_next = S_M6; end
      S_M6: begin
        if (stat.pused && stat.nused) state_next = S_MP0;
        else if (stat.pused)          state_next = S_MDN;
        else                          state_next = S_MDP;
      end
      S_MDP: begin
        ctl.cmd    = efla_pkg::C_DT_PB;
        ret_next   = stat.nused ? S_MFIN : S_MDN;
        state_next = S_D0;
      end
      S_MDN: begin
        ctl.cmd    = efla_pkg::C_DT_NB;
        ret_next   = S_MFIN;
        state_next = S_D0;
      end
      S_MFIN: begin
        ctl.cmd    = efla_pkg::C_MFIN;
        state_next = S_MT0;
      end
      S_MT0: begin
        ctl.cmd    = efla_pkg::C_TAGH;
        state_next = S_MT1;
      end
      S_MT1: begin
        ctl.cmd    = efla_pkg::C_TAGF;
        state_next = S_MP0;
      end
      // Push at list head
      S_MP0: begin ctl.cmd = efla_pkg::C_P0; state_next = S_MP1; end
      S_MP1: begin ctl.cmd = efla_pkg::C_P1; state_next = S_MP2; end
      S_MP2: begin
        ctl.cmd = efla_pkg::C_P2;
        case (caller)
          CL_ALLOC: state_next = S_C0;
          CL_CARVE: state_next = S_AEND;
          CL_INIT: begin
            ctl.st_we  = 1'b1;
            ctl.st_val = efla_pkg::ST_OK;
            state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      // Unlink a block from the list
      S_D0: begin ctl.cmd = efla_pkg::C_D0; state_next = S_D1; end
      S_D1: begin
        ctl.cmd    = efla_pkg::C_D1;
        state_next = stat.head_eq ? ret : S_D2;
      end
      S_D2: begin ctl.cmd = efla_pkg::C_D2; state_next = S_D3; end
      S_D3: begin ctl.cmd = efla_pkg::C_D3; state_next = ret; end
      // Take the chosen block, split when the rest is large enough
      S_C0: begin ctl.cmd = efla_pkg::C_C0; state_next = S_C1; end
      S_C1: begin
        ctl.cmd     = efla_pkg::C_C1;
        caller_next = CL_CARVE;
        ret_next    = S_C2;
        state_next  = S_D0;
      end
      S_C2: begin ctl.cmd = efla_pkg::C_C2; state_next = S_C3; end
      S_C3: begin
        ctl.cmd      = efla_pkg::C_TAGH;
        ctl.tag_used = 1'b1;
        state_next   = S_C4;
      end
      S_C4: begin
        ctl.cmd      = efla_pkg::C_TAGF;
        ctl.tag_used = 1'b1;
        state_next   = stat.split_ok ? S_C5 : S_AEND;
      end
      S_C5: begin ctl.cmd = efla_pkg::C_C5;   state_next = S_C6; end
      S_C6: begin ctl.cmd = efla_pkg::C_TAGH; state_next = S_C7; end
      S_C7: begin ctl.cmd = efla_pkg::C_TAGF; state_next = S_MP0; end
      S_AEND: begin
        ctl.cmd    = efla_pkg::C_AEND;
        ctl.st_we  = 1'b1;
        ctl.st_val = efla_pkg::ST_OK;
        if (free_after) begin
          free_after_next = 1'b0;
          caller_next     = CL_FREE;
          state_next      = S_F0;
        end else begin
          state_next = S_DONE;
        end
      end
      // Free: clear allocated bit, then coalesce
      S_F0: begin ctl.cmd = efla_pkg::C_F0;   state_next = S_F1; end
      S_F1: begin ctl.cmd = efla_pkg::C_F1;   state_next = S_F2; end
      S_F2: begin ctl.cmd = efla_pkg::C_TAGH; state_next = S_F3; end
      S_F3: begin ctl.cmd = efla_pkg::C_TAGF; state_next = S_M0; end
      // Init: frame words, then the first chunk
      S_I0: begin
        ctl.cmd = efla_pkg::C_I0;
        if (stat.lim_small) begin
          ctl.st_we  = 1'b1;
          ctl.st_val = efla_pkg::ST_OOM;
          state_next = S_DONE;
        end else begin
          state_next = S_IW;
        end
      end
      S_IW: begin
        ctl.cmd = efla_pkg::C_IW;
        if (stat.iw_last) state_next = S_I7;
      end
      S_I7: begin ctl.cmd = efla_pkg::C_I7; state_next = S_G0; end
      // Hand the result to the output register
      S_DONE: begin
        if (!result_valid || result_ready) begin
          ctl.ld_out        = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      caller       <= CL_INIT;
      free_after   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      ret          <= ret_next;
      caller       <= caller_next;
      free_after   <= free_after_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/explicit_free_list_allocator_core.sv
// Top level of the explicit free-list heap allocator.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  item     | item_valid / item_ready    | action, request_bytes, block_addr
//  result   | result_valid / result_ready| result_addr, status
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item at a time, one heap access per cycle; each item passes a decode and a result state.
// Allocate: size the request, walk the free list first-fit, then unlink, tag and split the block,
// growing the heap when no block fits. Free: clear the allocated bit, coalesce and push.
// Reallocate: allocate, then free; a zero size only frees. Init: frame words plus growth.
// Synchronous reset; the heap memory is not cleared. A result waiting on
// result_ready holds the output register while the next item is accepted.
`default_nettype none
module explicit_free_list_allocator_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire efla_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output efla_pkg::out_item_t      result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_data
);

  efla_pkg::ctl_t  ctl;
  efla_pkg::stat_t stat;

  // Configuration transfers complete at once
  assign cfg_ready = 1'b1;

  efla_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .ctl          (ctl)
  );

  efla_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
`default_nettype wire

// File: rtl/efla_checker.sv
// Port-level checks for the allocator core, bound to the top level.
`default_nettype none
module efla_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_valid,
  input wire logic                item_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire efla_pkg::out_item_t result
);

  // After reset: nothing pending, ready for an item
  a_reset: assert property (@(posedge clk) rst |=> (!result_valid && item_ready))
    else $error("state not clean after reset");

  // An accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while busy");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // Any non-ok status carries a null address
  a_null: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != efla_pkg::ST_OK)) |-> (result.result_addr == 16'd0))
    else $error("address returned with failure status");

endmodule

bind explicit_free_list_allocator_core efla_checker u_chk (.*);
`default_nettype wire

// File: tb/explicit_free_list_allocator_core_tb.sv
// Testbench for the explicit free-list allocator core with a behavioral heap predictor.
`default_nettype none
module explicit_free_list_allocator_core_tb;

  localparam int          WATCHDOG_LIMIT = 60000;
  localparam int          SETTLE_CYCLES  = 300;
  localparam int          QUIET_TAIL     = 150;
  localparam logic [1:0]  CFG_SPARE      = 2'd2;

  typedef enum logic [1:0] {E_ITEM, E_CFG, E_DRAIN} entry_kind_t;

  typedef struct {
    entry_kind_t       kind;
    efla_pkg::action_t act;
    logic [16:0]       req;
    logic [15:0]       addr;
    bit                pick_live;
    logic [1:0]        reg_idx;
    logic [16:0]       reg_data;
  } work_entry_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  efla_pkg::in_item_t  item;
  logic                result_valid;
  logic                result_ready;
  efla_pkg::out_item_t result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [16:0]         cfg_data;

  explicit_free_list_allocator_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Behavioral heap state
  logic [31:0] heap_img [efla_pkg::HEAP_WORDS];
  int unsigned heap_brk;
  int unsigned list_head;
  bit          heap_ready;
  int unsigned chunk_sz;
  int unsigned limit_sz;

  work_entry_t         work_q[$];
  efla_pkg::out_item_t pending_results[$];
  logic [15:0]         live_blocks[$];
  int                  errors;
  int                  idle_cycles;

  function automatic int unsigned hrd(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < efla_pkg::HEAP_WORDS) ? heap_img[i] : 0;
  endfunction

  function automatic void hwr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < efla_pkg::HEAP_WORDS) heap_img[i] = v;
  endfunction

  function automatic int unsigned bsize(int unsigned bp);
    return hrd(bp - 4) & efla_pkg::SIZE_MASK;
  endfunction

  function automatic int unsigned bnext(int unsigned bp);
    return bp + bsize(bp);
  endfunction

  function automatic int unsigned bprev(int unsigned bp);
    return bp - (hrd(bp - 8) & efla_pkg::SIZE_MASK);
  endfunction

  function automatic void tag_block(int unsigned bp, int unsigned sz, int unsigned used);
    hwr(bp - 4, sz | used);
    hwr(bp + sz - 8, sz | used);
  endfunction

  // LIFO free list
  function automatic void list_insert(int unsigned bp);
    hwr(bp + 4, list_head);
    hwr(bp, 0);
    hwr(list_head, bp);
    list_head = bp & 16'hFFFF;
  endfunction

  function automatic void list_unlink(int unsigned bp);
    int unsigned s, p;
    s = hrd(bp + 4);
    if (bp == list_head) begin
      hwr(s, 0);
      list_head = s & 16'hFFFF;
    end else begin
      p = hrd(bp);
      hwr(p + 4, s);
      hwr(s, p);
    end
  endfunction

  // Boundary-tag coalescing
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned pu, nu, sz;
    pu = hrd(bprev(bp) + bsize(bprev(bp)) - 8) & 1;
    nu = hrd(bnext(bp) - 4) & 1;
    sz = bsize(bp);
    if (pu != 0 && nu == 0) begin
      list_unlink(bnext(bp));
      sz += bsize(bnext(bp));
      tag_block(bp, sz, 0);
    end else if (pu == 0 && nu != 0) begin
      list_unlink(bprev(bp));
      sz += bsize(bprev(bp));
      bp = bprev(bp);
      tag_block(bp, sz, 0);
    end else if (pu == 0 && nu == 0) begin
      list_unlink(bprev(bp));
      list_unlink(bnext(bp));
      sz += bsize(bprev(bp)) + bsize(bnext(bp));
      bp = bprev(bp);
      tag_block(bp, sz, 0);
    end
    list_insert(bp);
    return bp;
  endfunction

  function automatic int unsigned eff_limit();
    int unsigned lim;
    lim = limit_sz;
    if (lim > efla_pkg::LIM_CAP) lim = efla_pkg::LIM_CAP;
    return lim;
  endfunction

  function automatic int unsigned heap_grow(int unsigned bytes);
    int unsigned w, sz, bp;
    w = bytes >> 2;
    if (w & 1) w++;
    sz = w * 4;
    if (sz < efla_pkg::MIN_BLOCK) sz = efla_pkg::MIN_BLOCK;
    if (heap_brk + sz > eff_limit()) return 0;
    bp = heap_brk;
    heap_brk += sz;
    tag_block(bp, sz, 0);
    hwr(bp + sz - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic int unsigned fit_search(int unsigned asz);
    int unsigned bp, steps;
    bp = list_head;
    steps = 0;
    while ((hrd(bp - 4) & 1) == 0 && steps < efla_pkg::WALK_BOUND) begin
      if (asz <= bsize(bp)) return bp;
      bp = hrd(bp + 4);
      steps++;
    end
    return 0;
  endfunction

  function automatic void place(int unsigned bp, int unsigned asz);
    int unsigned csz;
    csz = bsize(bp);
    list_unlink(bp);
    if (csz - asz >= efla_pkg::MIN_BLOCK && csz >= asz) begin
      tag_block(bp, asz, 1);
      tag_block(bp + asz, csz - asz, 0);
      list_insert(bp + asz);
    end else begin
      tag_block(bp, csz, 1);
    end
  endfunction

  function automatic logic [1:0] heap_alloc(int unsigned sz, output int unsigned addr);
    int unsigned asz, bp;
    addr = 0;
    if (sz == 0) return efla_pkg::ST_IGNORED;
    asz = (sz <= 8) ? efla_pkg::MIN_BLOCK : 8 * ((sz + 15) / 8);
    bp = fit_search(asz);
    if (bp == 0) begin
      bp = heap_grow((asz > chunk_sz) ? asz : chunk_sz);
      if (bp == 0) return efla_pkg::ST_OOM;
    end
    place(bp, asz);
    addr = bp;
    return efla_pkg::ST_OK;
  endfunction

  function automatic void heap_release(int unsigned bp);
    tag_block(bp, bsize(bp), 0);
    void'(coalesce(bp));
  endfunction

  function automatic logic [1:0] heap_setup();
    heap_brk = 0;
    list_head = 0;
    heap_ready = 0;
    if (eff_limit() < efla_pkg::FRAME_BYTES) return efla_pkg::ST_OOM;
    hwr(0, 0);
    hwr(4, efla_pkg::MIN_BLOCK | 1);
    hwr(8, 0);
    hwr(12, 0);
    hwr(16, efla_pkg::MIN_BLOCK | 1);
    hwr(20, 1);
    heap_brk = efla_pkg::FRAME_BYTES;
    list_head = 8;
    heap_ready = 1;
    return (heap_grow(chunk_sz) == 0) ? efla_pkg::ST_OOM : efla_pkg::ST_OK;
  endfunction

  function automatic void drop_live(logic [15:0] a);
    foreach (live_blocks[i])
      if (live_blocks[i] == a) begin
        live_blocks.delete(i);
        return;
      end
  endfunction

  // Expected response of one accepted request; also tracks live blocks
  function automatic efla_pkg::out_item_t alloc_predict(efla_pkg::in_item_t it);
    efla_pkg::out_item_t r;
    int unsigned         a;
    a = 0;
    if (it.action == efla_pkg::ACT_INIT) begin
      r.status = heap_setup();
      live_blocks.delete();
    end else if (!heap_ready) begin
      r.status = efla_pkg::ST_NOT_INIT;
    end else if (it.action == efla_pkg::ACT_ALLOC) begin
      r.status = heap_alloc(it.request_bytes, a);
    end else if (it.action == efla_pkg::ACT_FREE) begin
      if (it.block_addr == 0) r.status = efla_pkg::ST_IGNORED;
      else begin
        heap_release(it.block_addr);
        drop_live(it.block_addr);
        r.status = efla_pkg::ST_OK;
      end
    end else begin
      if (it.block_addr == 0) begin
        r.status = heap_alloc(it.request_bytes, a);
      end else if (it.request_bytes == 0) begin
        heap_release(it.block_addr);
        drop_live(it.block_addr);
        r.status = efla_pkg::ST_IGNORED;
      end else begin
        r.status = heap_alloc(it.request_bytes, a);
        if (r.status == efla_pkg::ST_OK) begin
          heap_release(it.block_addr);
          drop_live(it.block_addr);
        end
      end
    end
    r.result_addr = a[15:0];
    if (r.status == efla_pkg::ST_OK && a != 0) live_blocks.push_back(a[15:0]);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Request and config driver
  bit draining;
  int gap_left, drain_left;
  always @(posedge clk) begin
    logic               nv_i, nv_c;
    efla_pkg::in_item_t ni;
    logic [1:0]         nidx;
    logic [16:0]        ndata;
    work_entry_t        e;
    int                 gl, dl;
    bit                 dr;
    ni = item;
    nidx = cfg_index;
    ndata = cfg_data;
    gl = gap_left;
    dl = drain_left;
    dr = draining;
    if (rst) begin
      item_valid <= 0;
      cfg_valid <= 0;
      item <= '0;
      cfg_index <= efla_pkg::CFG_CHUNK;
      cfg_data <= '0;
      gap_left <= 0;
      draining <= 0;
      drain_left <= 0;
    end else begin
      nv_i = item_valid;
      nv_c = cfg_valid;
      if (item_valid && item_ready) begin
        pending_results.push_back(alloc_predict(item));
        nv_i = 0;
        if (work_q.size() > QUIET_TAIL && $urandom_range(7) == 0)
          gl = $urandom_range(15, 1);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == efla_pkg::CFG_CHUNK) chunk_sz = cfg_data;
        else if (cfg_index == efla_pkg::CFG_LIMIT) limit_sz = cfg_data;
        nv_c = 0;
      end
      if (dr) begin
        if (pending_results.size() == 0) begin
          dl = dl - 1;
          if (dl <= 0) dr = 0;
        end
      end else if (gl > 0) begin
        gl = gl - 1;
      end else if (!nv_i && !nv_c && work_q.size() > 0) begin
        e = work_q.pop_front();
        case (e.kind)
          E_DRAIN: begin
            dr = 1;
            dl = SETTLE_CYCLES;
          end
          E_CFG: begin
            nv_c = 1;
            nidx = e.reg_idx;
            ndata = e.reg_data;
          end
          default: begin
            nv_i = 1;
            ni.action = e.act;
            ni.request_bytes = e.req;
            ni.block_addr = e.addr;
            if (e.pick_live)
              ni.block_addr = (live_blocks.size() > 0) ?
                live_blocks[$urandom_range(live_blocks.size() - 1)] : 16'd0;
          end
        endcase
      end
      item_valid <= nv_i;
      item <= ni;
      cfg_valid <= nv_c;
      cfg_index <= nidx;
      cfg_data <= ndata;
      gap_left <= gl;
      draining <= dr;
      drain_left <= dl;
    end
  end

  // Response monitor with receiver stalls
  int stall_left;
  always @(posedge clk) begin
    efla_pkg::out_item_t x;
    if (rst) begin
      result_ready <= 0;
      stall_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual addr=%0d status=%0d",
                   $time, result.result_addr, result.status);
          errors++;
        end else begin
          x = pending_results.pop_front();
          if (x.result_addr !== result.result_addr) begin
            $display("%0t: result_addr mismatch expected %0d actual %0d",
                     $time, x.result_addr, result.result_addr);
            errors++;
          end
          if (x.status !== result.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, x.status, result.status);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 0;
      end else if (work_q.size() > QUIET_TAIL && $urandom_range(9) == 0) begin
        stall_left <= $urandom_range(15, 1) - 1;
        result_ready <= 0;
      end else begin
        result_ready <= 1;
      end
      // Watchdog on transfers of any kind
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_op(efla_pkg::action_t a, int unsigned req, int unsigned addr, bit pick);
    work_entry_t e;
    e.kind = E_ITEM;
    e.act = a;
    e.req = req[16:0];
    e.addr = addr[15:0];
    e.pick_live = pick;
    e.reg_idx = efla_pkg::CFG_CHUNK;
    e.reg_data = '0;
    work_q.push_back(e);
  endtask

  task automatic add_cfg(logic [1:0] idx, int unsigned data);
    work_entry_t e;
    e.kind = E_DRAIN;
    work_q.push_back(e);
    e.kind = E_CFG;
    e.reg_idx = idx;
    e.reg_data = data[16:0];
    e.pick_live = 0;
    work_q.push_back(e);
  endtask

  function automatic int unsigned rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return 0;
    if (p < 70) return $urandom_range(64, 1);
    if (p < 90) return $urandom_range(1024, 65);
    if (p < 98) return $urandom_range(8192, 1025);
    return $urandom_range(65536, 8193);
  endfunction

  task automatic add_random(int n);
    int unsigned p;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 45) add_op(efla_pkg::ACT_ALLOC, rand_size(), 0, 0);
      else if (p < 78) add_op(efla_pkg::ACT_FREE, 0, 0, 1);
      else if (p < 80) add_op(efla_pkg::ACT_FREE, 0, 0, 0);
      else if (p < 93) add_op(efla_pkg::ACT_REALLOC, rand_size(), 0, 1);
      else if (p < 98) add_op(efla_pkg::ACT_REALLOC, rand_size(), 0, 0);
      else add_op(efla_pkg::ACT_INIT, 0, 0, 0);
    end
  endtask

  task automatic add_phase(int unsigned chunk, int unsigned lim, int n);
    add_cfg(efla_pkg::CFG_CHUNK, chunk);
    add_cfg(efla_pkg::CFG_LIMIT, lim);
    add_op(efla_pkg::ACT_INIT, 0, 0, 0);
    add_random(n);
  endtask

  initial begin
    errors = 0;
    heap_brk = 0;
    list_head = 0;
    heap_ready = 0;
    chunk_sz = efla_pkg::CHUNK_RESET;
    limit_sz = efla_pkg::LIMIT_RESET;
    rst = 1;
    // Directed: before init, then extremes on the reset configuration
    add_op(efla_pkg::ACT_ALLOC, 16, 0, 0);
    add_op(efla_pkg::ACT_FREE, 0, 24, 0);
    add_op(efla_pkg::ACT_REALLOC, 8, 0, 0);
    add_op(efla_pkg::ACT_INIT, 0, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 0, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 1, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 8, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 9, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 65536, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 40000, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 20000, 0, 0);
    add_op(efla_pkg::ACT_ALLOC, 65535, 0, 0);
    add_op(efla_pkg::ACT_FREE, 0, 0, 0);
    add_op(efla_pkg::ACT_FREE, 0, 0, 1);
    add_op(efla_pkg::ACT_REALLOC, 24, 0, 0);
    add_op(efla_pkg::ACT_REALLOC, 0, 0, 1);
    add_op(efla_pkg::ACT_REALLOC, 100, 0, 1);
    add_op(efla_pkg::ACT_REALLOC, 65536, 0, 1);
    add_op(efla_pkg::ACT_REALLOC, 0, 0, 0);
    add_op(efla_pkg::ACT_FREE, 0, 0, 1);
    add_op(efla_pkg::ACT_FREE, 0, 0, 1);
    add_op(efla_pkg::ACT_FREE, 0, 0, 1);
    add_random(300);
    // Unused register index must be harmless
    add_cfg(CFG_SPARE, 17'h1FFFF);
    add_phase(8, 24, 20);
    add_phase(8, 8, 15);
    add_phase(65536, 65536, 40);
    add_phase(16, 512, 250);
    add_phase(8 * $urandom_range(64, 1), 24 + 8 * $urandom_range(4000, 10), 300);
    add_phase(8 * $urandom_range(8192, 1), 65536, 300);
    add_phase(1024, 8192, 300);
    add_phase(4096, 65536, 400);
    repeat (10) @(posedge clk);
    rst <= 0;
    // Wait for the queue to empty and every result to arrive
    while (work_q.size() != 0 || item_valid || cfg_valid || draining ||
           pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/efla_pkg.sv
rtl/efla_dpath.sv
rtl/efla_ctrl.sv
rtl/explicit_free_list_allocator_core.sv
rtl/efla_checker.sv
tb/explicit_free_list_allocator_core_tb.sv
